// ----- hw/rtl/utc_pkg.sv -----
// Package with constants and the arctangent table for the tracking controller.
`default_nettype none
package utc_pkg;
    localparam int CfgIdxWidth = 2;
    localparam logic [CfgIdxWidth-1:0] REG_GAIN_LONGITUDINAL = 2'd0;
    localparam logic [CfgIdxWidth-1:0] REG_GAIN_LATERAL      = 2'd1;
    localparam logic [CfgIdxWidth-1:0] REG_GAIN_HEADING      = 2'd2;

    localparam logic [15:0] GAIN_RESET = 16'd256;

    // Angles in Q2.29.
    localparam logic signed [34:0] ANG_TWO_PI  = 35'sd3373259426;
    localparam logic signed [34:0] ANG_PI      = 35'sd1686629713;
    localparam logic signed [34:0] ANG_HALF_PI = 35'sd843314857;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

    function automatic logic signed [31:0] atan_q29(input int idx);
        logic signed [31:0] v;
        unique case (idx)
            0:  v = 32'sd421657428;
            1:  v = 32'sd248918915;
            2:  v = 32'sd131521918;
            3:  v = 32'sd66762579;
            4:  v = 32'sd33510843;
            5:  v = 32'sd16771758;
            6:  v = 32'sd8387925;
            7:  v = 32'sd4194219;
            8:  v = 32'sd2097141;
            9:  v = 32'sd1048575;
            10: v = 32'sd524288;
            11: v = 32'sd262144;
            12: v = 32'sd131072;
            13: v = 32'sd65536;
            14: v = 32'sd32768;
            15: v = 32'sd16384;
            16: v = 32'sd8192;
            17: v = 32'sd4096;
            18: v = 32'sd2048;
            19: v = 32'sd1024;
            20: v = 32'sd512;
            21: v = 32'sd256;
            22: v = 32'sd128;
            23: v = 32'sd64;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/utc_sincos.sv -----
// Pipelined CORDIC sine and cosine of a Q3.13 angle, results in Q16.
`default_nettype none
module utc_sincos #(
    parameter int ITER = 16
) (
    input  wire                 aclk,
    input  wire                 en,
    input  wire  signed [16:0]  angle,
    output logic signed [18:0]  sin_out,
    output logic signed [18:0]  cos_out
);
    import utc_pkg::*;

    logic signed [34:0] z_full;
    logic signed [34:0] z_red;
    logic signed [34:0] z_fold;
    logic               fold_neg;

    logic signed [32:0] x_reg [0:ITER];
    logic signed [32:0] y_reg [0:ITER];
    logic signed [31:0] z_reg [0:ITER];
    logic               neg_reg [0:ITER];

    logic signed [32:0] x_fin;
    logic signed [32:0] y_fin;
    logic signed [32:0] x_rnd;
    logic signed [32:0] y_rnd;
    logic signed [18:0] sin_reg;
    logic signed [18:0] cos_reg;

    // One wrap is enough for the range of a 17 bit angle difference.
    always_comb begin
        z_full = {{2{angle[16]}}, angle, 16'b0};
        if (z_full > ANG_PI) begin
            z_red = z_full - ANG_TWO_PI;
        end else if (z_full < -ANG_PI) begin
            z_red = z_full + ANG_TWO_PI;
        end else begin
            z_red = z_full;
        end
        if (z_red > ANG_HALF_PI) begin
            z_fold   = z_red - ANG_PI;
            fold_neg = 1'b1;
        end else if (z_red < -ANG_HALF_PI) begin
            z_fold   = z_red + ANG_PI;
            fold_neg = 1'b1;
        end else begin
            z_fold   = z_red;
            fold_neg = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= CORDIC_GAIN;
            y_reg[0]   <= '0;
            z_reg[0]   <= z_fold[31:0];
            neg_reg[0] <= fold_neg;
            for (int i = 0; i < ITER; i++) begin
                if (!z_reg[i][31]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - atan_q29(i);
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + atan_q29(i);
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    always_comb begin
        x_fin = neg_reg[ITER] ? -x_reg[ITER] : x_reg[ITER];
        y_fin = neg_reg[ITER] ? -y_reg[ITER] : y_reg[ITER];
        x_rnd = x_fin + 33'sd8192;
        y_rnd = y_fin + 33'sd8192;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= x_rnd[32:14];
            sin_reg <= y_rnd[32:14];
        end
    end

    assign sin_out = sin_reg;
    assign cos_out = cos_reg;
endmodule
`default_nettype wire

// ----- hw/rtl/unicycle_tracking_controller_unit.sv -----
// Top level of the pipelined unicycle trajectory tracking controller.
//
// Input channel (s_ ports): one transfer carries the measured pose and the
// reference pose, speed and turn rate. Result channel (m_ ports): one
// transfer per input carries the speed and turn commands and a flag that is
// set when either command was clipped to 16 bits.
// Gains are written through cfg_wr_en / cfg_index / cfg_wdata while idle;
// reset sets each gain to 1.0. Unknown indexes are ignored.
// From input transfer to result valid, an item passes one input stage,
// the CORDIC chain (one stage per iteration plus a fold stage and a rounding
// stage) and six stages of multiply, round and saturate. Throughput is one
// item per cycle while the receiver takes each result.
// The whole pipeline advances on a single enable: when the result register
// holds an item that the receiver does not take, every stage holds and
// s_ready drops, so nothing is lost or repeated.
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none
module unicycle_tracking_controller_unit #(
    parameter int TRIG_ITERATIONS = 16
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                cfg_wr_en,
    input  wire         [1:0]  cfg_index,
    input  wire         [15:0] cfg_wdata,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire  signed [31:0] s_actual_x,
    input  wire  signed [31:0] s_actual_y,
    input  wire  signed [15:0] s_actual_heading,
    input  wire  signed [31:0] s_reference_x,
    input  wire  signed [31:0] s_reference_y,
    input  wire  signed [15:0] s_reference_heading,
    input  wire  signed [15:0] s_reference_speed,
    input  wire  signed [15:0] s_reference_turn_rate,
    output logic               m_valid,
    input  wire                m_ready,
    output logic signed [15:0] m_speed_command,
    output logic signed [15:0] m_turn_command,
    output logic               m_saturated
);
    import utc_pkg::*;

    localparam int DLY = TRIG_ITERATIONS + 2;
    localparam int NSTG = DLY + 7;

    logic        en;
    logic [15:0] gain_long_reg;
    logic [15:0] gain_lat_reg;
    logic [15:0] gain_head_reg;
    logic        valid_reg [0:NSTG-1];

    // Stage 0 registers.
    logic signed [32:0] dx0_reg;
    logic signed [32:0] dy0_reg;
    logic signed [16:0] ah0_reg;
    logic signed [16:0] dth0_reg;
    logic signed [15:0] vref0_reg;
    logic signed [15:0] wref0_reg;

    logic signed [32:0] dx_dly_reg   [0:DLY-1];
    logic signed [32:0] dy_dly_reg   [0:DLY-1];
    logic signed [15:0] vref_dly_reg [0:DLY-1];
    logic signed [15:0] wref_dly_reg [0:DLY-1];

    logic signed [18:0] sa;
    logic signed [18:0] ca;
    logic signed [18:0] sd;
    logic signed [18:0] cd;

    // Rotation products.
    logic signed [51:0] p_cdx_reg;
    logic signed [51:0] p_sdy_reg;
    logic signed [51:0] p_cdy_reg;
    logic signed [51:0] p_sdx_reg;
    logic signed [18:0] sd1_reg;
    logic signed [18:0] cd1_reg;
    logic signed [15:0] vref1_reg;
    logic signed [15:0] wref1_reg;

    // Rounded robot-frame errors.
    logic signed [52:0] fwd_sum;
    logic signed [52:0] side_sum;
    logic signed [36:0] fwd2_reg;
    logic signed [36:0] side2_reg;
    logic signed [18:0] sd2_reg;
    logic signed [18:0] cd2_reg;
    logic signed [15:0] vref2_reg;
    logic signed [15:0] wref2_reg;

    // Gain products and the reference speed product.
    logic signed [53:0] p_gfwd_reg;
    logic signed [34:0] p_vcd_reg;
    logic signed [53:0] p_gside_reg;
    logic signed [35:0] p_gsd_reg;
    logic signed [15:0] vref3_reg;
    logic signed [15:0] wref3_reg;

    // Speed result and inner turn term.
    logic signed [54:0] spd_sum;
    logic signed [54:0] inner_sum;
    logic signed [38:0] spd_rnd;
    logic signed [15:0] spd4_reg;
    logic               clip4_reg;
    logic signed [42:0] inner4_reg;
    logic signed [15:0] vref4_reg;
    logic signed [15:0] wref4_reg;

    logic signed [58:0] p_vin5_reg;
    logic signed [15:0] wref5_reg;
    logic signed [15:0] spd5_reg;
    logic               clip5_reg;

    logic signed [59:0] trn_sum;
    logic signed [47:0] trn_rnd;
    logic signed [15:0] trn_sat;
    logic               trn_clip;

    logic signed [15:0] spd_out_reg;
    logic signed [15:0] trn_out_reg;
    logic               sat_out_reg;

    assign en      = !valid_reg[NSTG-1] || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_long_reg <= GAIN_RESET;
            gain_lat_reg  <= GAIN_RESET;
            gain_head_reg <= GAIN_RESET;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_GAIN_LONGITUDINAL) begin
                gain_long_reg <= cfg_wdata;
            end
            if (cfg_index == REG_GAIN_LATERAL) begin
                gain_lat_reg <= cfg_wdata;
            end
            if (cfg_index == REG_GAIN_HEADING) begin
                gain_head_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NSTG; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            valid_reg[0] <= s_valid;
            for (int k = 1; k < NSTG; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dx0_reg   <= {s_reference_x[31], s_reference_x} - {s_actual_x[31], s_actual_x};
            dy0_reg   <= {s_reference_y[31], s_reference_y} - {s_actual_y[31], s_actual_y};
            ah0_reg   <= {s_actual_heading[15], s_actual_heading};
            dth0_reg  <= {s_reference_heading[15], s_reference_heading}
                         - {s_actual_heading[15], s_actual_heading};
            vref0_reg <= s_reference_speed;
            wref0_reg <= s_reference_turn_rate;

            dx_dly_reg[0]   <= dx0_reg;
            dy_dly_reg[0]   <= dy0_reg;
            vref_dly_reg[0] <= vref0_reg;
            wref_dly_reg[0] <= wref0_reg;
            for (int k = 1; k < DLY; k++) begin
                dx_dly_reg[k]   <= dx_dly_reg[k-1];
                dy_dly_reg[k]   <= dy_dly_reg[k-1];
                vref_dly_reg[k] <= vref_dly_reg[k-1];
                wref_dly_reg[k] <= wref_dly_reg[k-1];
            end
        end
    end

    utc_sincos #(.ITER(TRIG_ITERATIONS)) u_sincos_actual (
        .aclk    (aclk),
        .en      (en),
        .angle   (ah0_reg),
        .sin_out (sa),
        .cos_out (ca)
    );

    utc_sincos #(.ITER(TRIG_ITERATIONS)) u_sincos_delta (
        .aclk    (aclk),
        .en      (en),
        .angle   (dth0_reg),
        .sin_out (sd),
        .cos_out (cd)
    );

    always_comb begin
        fwd_sum  = 53'(p_cdx_reg) + 53'(p_sdy_reg) + 53'sd32768;
        side_sum = 53'(p_cdy_reg) - 53'(p_sdx_reg) + 53'sd32768;
        spd_sum  = 55'(p_vcd_reg) + 55'(p_gfwd_reg) + 55'sd32768;
        spd_rnd  = spd_sum[54:16];
        inner_sum = 55'(p_gside_reg) + 55'(p_gsd_reg) + 55'sd2048;
        trn_sum  = 60'(p_vin5_reg) + (60'(wref5_reg) <<< 12) + 60'sd2048;
        trn_rnd  = trn_sum[59:12];
        if (trn_rnd > 48'sd32767) begin
            trn_sat  = 16'sh7FFF;
            trn_clip = 1'b1;
        end else if (trn_rnd < -48'sd32768) begin
            trn_sat  = 16'sh8000;
            trn_clip = 1'b1;
        end else begin
            trn_sat  = trn_rnd[15:0];
            trn_clip = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_cdx_reg <= 52'(ca) * 52'(dx_dly_reg[DLY-1]);
            p_sdy_reg <= 52'(sa) * 52'(dy_dly_reg[DLY-1]);
            p_cdy_reg <= 52'(ca) * 52'(dy_dly_reg[DLY-1]);
            p_sdx_reg <= 52'(sa) * 52'(dx_dly_reg[DLY-1]);
            sd1_reg   <= sd;
            cd1_reg   <= cd;
            vref1_reg <= vref_dly_reg[DLY-1];
            wref1_reg <= wref_dly_reg[DLY-1];

            fwd2_reg  <= fwd_sum[52:16];
            side2_reg <= side_sum[52:16];
            sd2_reg   <= sd1_reg;
            cd2_reg   <= cd1_reg;
            vref2_reg <= vref1_reg;
            wref2_reg <= wref1_reg;

            p_gfwd_reg  <= $signed({1'b0, gain_long_reg}) * fwd2_reg;
            p_vcd_reg   <= 35'(vref2_reg) * 35'(cd2_reg);
            p_gside_reg <= $signed({1'b0, gain_lat_reg}) * side2_reg;
            p_gsd_reg   <= 36'($signed({1'b0, gain_head_reg})) * 36'(sd2_reg);
            vref3_reg   <= vref2_reg;
            wref3_reg   <= wref2_reg;

            if (spd_rnd > 39'sd32767) begin
                spd4_reg  <= 16'sh7FFF;
                clip4_reg <= 1'b1;
            end else if (spd_rnd < -39'sd32768) begin
                spd4_reg  <= 16'sh8000;
                clip4_reg <= 1'b1;
            end else begin
                spd4_reg  <= spd_rnd[15:0];
                clip4_reg <= 1'b0;
            end
            inner4_reg <= inner_sum[54:12];
            vref4_reg  <= vref3_reg;
            wref4_reg  <= wref3_reg;

            p_vin5_reg <= 59'(vref4_reg) * 59'(inner4_reg);
            wref5_reg  <= wref4_reg;
            spd5_reg   <= spd4_reg;
            clip5_reg  <= clip4_reg;

            spd_out_reg <= spd5_reg;
            trn_out_reg <= trn_sat;
            sat_out_reg <= clip5_reg | trn_clip;
        end
    end

    assign m_valid         = valid_reg[NSTG-1];
    assign m_speed_command = spd_out_reg;
    assign m_turn_command  = trn_out_reg;
    assign m_saturated     = sat_out_reg;
endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the unicycle tracking controller unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import utc_pkg::*;

    localparam int TRIG_STEPS = 16;
    localparam int PIPE_DEPTH = TRIG_STEPS + 9;
    localparam int STALL_LIMIT = 2000;
    localparam int RANDOM_POSES = 700;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [15:0] ah;
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [15:0] rh;
        logic signed [15:0] vref;
        logic signed [15:0] wref;
    } pose_t;

    typedef struct packed {
        logic signed [15:0] spd;
        logic signed [15:0] trn;
        logic               clip;
    } command_t;

    typedef struct {
        pose_t    pose;
        logic     typed;
        command_t want;
    } directed_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    pose_t pose_drv = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [15:0] m_speed_command;
    logic signed [15:0] m_turn_command;
    logic m_saturated;

    logic [15:0] k_long = GAIN_RESET;
    logic [15:0] k_lat = GAIN_RESET;
    logic [15:0] k_head = GAIN_RESET;

    command_t pending_commands[$];
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int failures = 0;
    int poses_sent = 0;
    int commands_seen = 0;
    int clipped_seen = 0;
    int quiet_cycles = 0;

    unicycle_tracking_controller_unit #(.TRIG_ITERATIONS(TRIG_STEPS)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_actual_x(pose_drv.ax), .s_actual_y(pose_drv.ay),
        .s_actual_heading(pose_drv.ah),
        .s_reference_x(pose_drv.rx), .s_reference_y(pose_drv.ry),
        .s_reference_heading(pose_drv.rh),
        .s_reference_speed(pose_drv.vref), .s_reference_turn_rate(pose_drv.wref),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_speed_command(m_speed_command), .m_turn_command(m_turn_command),
        .m_saturated(m_saturated)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_off(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint sat16(longint v, inout logic clip);
        if (v > 32767) begin
            clip = 1'b1;
            return 32767;
        end
        if (v < -32768) begin
            clip = 1'b1;
            return -32768;
        end
        return v;
    endfunction

    // Rotation CORDIC on a Q3.13 angle of any value; sine and cosine in Q16.
    function automatic void trig_q16(input longint ang_q13, output longint sn,
                                     output longint cs);
        longint z, x, y, t;
        logic flip;
        longint atan_tbl[16] = '{421657428, 248918915, 131521918, 66762579,
            33510843, 16771758, 8387925, 4194219, 2097141, 1048575, 524288,
            262144, 131072, 65536, 32768, 16384};
        z = ang_q13 * 65536;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        while (z > 1686629713) z -= 64'sd3373259426;
        while (z < -1686629713) z += 64'sd3373259426;
        if (z > 843314857) begin
            z -= 1686629713;
            flip = 1'b1;
        end else if (z < -843314857) begin
            z += 1686629713;
            flip = 1'b1;
        end
        for (int i = 0; i < TRIG_STEPS; i++) begin
            if (z >= 0) begin
                t = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                z -= atan_tbl[i];
            end else begin
                t = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                z += atan_tbl[i];
            end
            x = t;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        cs = round_off(x, 14);
        sn = round_off(y, 14);
    endfunction

    function automatic command_t tracking_law(pose_t p);
        longint sa, ca, sd, cd, dx, dy, fwd, side, spd, inner, trn;
        logic clip;
        command_t c;
        clip = 1'b0;
        dx = longint'(p.rx) - longint'(p.ax);
        dy = longint'(p.ry) - longint'(p.ay);
        trig_q16(longint'(p.ah), sa, ca);
        trig_q16(longint'(p.rh) - longint'(p.ah), sd, cd);
        fwd = round_off(ca * dx + sa * dy, 16);
        side = round_off(ca * dy - sa * dx, 16);
        spd = longint'(p.vref) * cd + longint'(k_long) * fwd;
        spd = sat16(round_off(spd, 16), clip);
        inner = longint'(k_lat) * side + longint'(k_head) * sd;
        inner = round_off(inner, 12);
        trn = longint'(p.vref) * inner + longint'(p.wref) * 4096;
        trn = sat16(round_off(trn, 12), clip);
        c.spd = spd[15:0];
        c.trn = trn[15:0];
        c.clip = clip;
        return c;
    endfunction

    task automatic write_gain(input logic [1:0] idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_GAIN_LONGITUDINAL) k_long = val;
        else if (idx == REG_GAIN_LATERAL) k_lat = val;
        else if (idx == REG_GAIN_HEADING) k_head = val;
    endtask

    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (pending_commands.size() != 0) @(negedge aclk);
        repeat (PIPE_DEPTH + 4) @(negedge aclk);
    endtask

    // Drives one pose and waits for its transfer; the expected command is
    // queued at the accepting edge by the monitor below. Valid stays high
    // into the next pose unless the sender idles.
    task automatic send_pose(input pose_t p);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        pose_drv <= p;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        poses_sent++;
    endtask

    function automatic pose_t random_pose();
        pose_t p;
        int mode;
        p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        mode = $urandom_range(9);
        if (mode < 6) begin
            // Small tracking errors near a common point keep results unclipped at small gains.
            p.ax = $urandom;
            p.ay = $urandom;
            p.rx = p.ax + $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            p.ry = p.ay + $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            p.ah = 16'($signed($urandom_range(0, 51472)) - 25736);
            p.rh = 16'($signed($urandom_range(0, 51472)) - 25736);
            p.vref = 16'($signed($urandom_range(0, 2048)) - 1024);
            p.wref = 16'($signed($urandom_range(0, 2048)) - 1024);
        end
        return p;
    endfunction

    // Accepted poses are predicted at the edge where they transfer.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            pending_commands.insert(pending_commands.size(), tracking_law(pose_drv));
    end

    always @(posedge aclk) begin
        command_t want;
        if (aresetn && m_valid && m_ready) begin
            commands_seen++;
            if (m_saturated) clipped_seen++;
            if (pending_commands.size() == 0) begin
                $display("%0t: unexpected command spd=%0d trn=%0d sat=%0b", $time,
                         m_speed_command, m_turn_command, m_saturated);
                failures++;
            end else begin
                want = pending_commands.pop_front();
                if (m_speed_command !== want.spd) begin
                    $display("%0t: speed_command expected %0d actual %0d", $time,
                             want.spd, m_speed_command);
                    failures++;
                end
                if (m_turn_command !== want.trn) begin
                    $display("%0t: turn_command expected %0d actual %0d", $time,
                             want.trn, m_turn_command);
                    failures++;
                end
                if (m_saturated !== want.clip) begin
                    $display("%0t: saturated expected %0b actual %0b", $time,
                             want.clip, m_saturated);
                    failures++;
                end
            end
        end
    end

    always @(negedge aclk) m_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) quiet_cycles <= 0;
        else if (s_valid || pending_commands.size() != 0) quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Directed rows; typed expectations are checked against the predictor too.
    directed_row_t directed[] = '{
        '{'{0, 0, 0, 0, 0, 0, 0, 0}, 1'b1, '{16'sd0, 16'sd0, 1'b0}},
        '{'{0, 0, 0, 0, 0, 0, 256, 0}, 1'b1, '{16'sd256, 16'sd0, 1'b0}},
        '{'{0, 0, 0, 0, 0, 0, 0, -32768}, 1'b1, '{16'sd0, -16'sd32768, 1'b0}},
        '{'{0, 0, 0, 0, 0, 0, 0, 32767}, 1'b1, '{16'sd0, 16'sd32767, 1'b0}},
        '{'{32'sh80000000, 0, 0, 32'sh7fffffff, 0, 0, 0, 0}, 1'b1,
          '{16'sd32767, 16'sd0, 1'b1}},
        '{'{32'sh7fffffff, 32'sh7fffffff, 0, 32'sh80000000, 32'sh80000000, 0,
            -32768, -32768}, 1'b0, '0},
        '{'{0, 0, 25736, 0, 0, -25736, 512, 128}, 1'b0, '0},
        '{'{0, 0, -32768, 0, 0, 32767, -512, 0}, 1'b0, '0},
        '{'{0, 0, 32767, 65536, 0, -32768, 32767, 32767}, 1'b0, '0},
        '{'{100, -100, 12868, 65536, 65536, 0, 1000, -200}, 1'b0, '0},
        '{'{0, 0, 0, 0, 32'sh01000000, 0, 32767, 0}, 1'b0, '0},
        '{'{0, 0, -12868, 0, 0, 12868, -1000, 300}, 1'b0, '0}
    };

    initial begin
        command_t want;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (directed[i]) begin
            if (directed[i].typed) begin
                want = tracking_law(directed[i].pose);
                if (want !== directed[i].want) begin
                    $display("%0t: row %0d typed expectation %h, predictor %h", $time, i,
                             directed[i].want, want);
                    failures++;
                end
            end
            send_pose(directed[i].pose);
        end
        drain_pipeline();
        write_gain(REG_GAIN_LONGITUDINAL, 16'hffff);
        write_gain(REG_GAIN_LATERAL, 16'hffff);
        write_gain(REG_GAIN_HEADING, 16'hffff);
        write_gain(2'd3, 16'h1234);
        foreach (directed[i]) send_pose(directed[i].pose);
        drain_pipeline();
        write_gain(REG_GAIN_LONGITUDINAL, 16'h0000);
        write_gain(REG_GAIN_LATERAL, 16'h0000);
        write_gain(REG_GAIN_HEADING, 16'h0000);
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 52 : 0;
            recv_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 37 : 0;
            for (int n = 0; n < RANDOM_POSES / 3; n++) begin
                if (n % 60 == 59) begin
                    drain_pipeline();
                    write_gain(2'($urandom_range(0, 3)), (n % 120 == 59) ?
                               16'($urandom_range(0, 1024)) : 16'($urandom));
                end
                send_pose(random_pose());
                if ($urandom_range(99) < 5) begin
                    s_valid <= 1'b0;
                    repeat ($urandom_range(1, 30)) @(negedge aclk);
                end
            end
            drain_pipeline();
        end
        recv_idle_pct = 0;
        $display("Sent %0d poses, checked %0d commands, %0d of them clipped.",
                 poses_sent, commands_seen, clipped_seen);
        $display("Gains swept from zero to full scale under sender and receiver stalls.");
        if (failures == 0 && pending_commands.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire
